### rtl/timer_and_interrupt_controller_unit_macros.svh
// Assertion macros for the timer and interrupt controller
`ifndef TIMER_AND_INTERRUPT_CONTROLLER_UNIT_MACROS_SVH
`define TIMER_AND_INTERRUPT_CONTROLLER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TIC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tic: same-cycle check failed");
`define TIC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tic: next-cycle check failed");
`else
`define TIC_ASSERT_IMP(label, ante, cons)
`define TIC_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/tic_pkg.sv
// Shared constants, codes and controller types of the timer and interrupt controller
`timescale 1ns / 1ps
package tic_pkg;

    localparam int FuncW    = 2;
    localparam int ByteW    = 8;
    localparam int SelW     = 3;
    localparam int VecW     = 7;
    localparam int TotalW   = 9;
    localparam int PeriodW  = 11;
    localparam int PrescW   = 12;
    localparam int CfgIdxW  = 1;
    localparam int NumSrc   = 5;
    localparam int SrcIdxW  = 3;

    localparam logic [FuncW-1:0] FUNC_ADVANCE = 2'd0;
    localparam logic [FuncW-1:0] FUNC_WRITE   = 2'd1;
    localparam logic [FuncW-1:0] FUNC_READ    = 2'd2;
    localparam logic [FuncW-1:0] FUNC_RAISE   = 2'd3;

    localparam logic [SelW-1:0] SEL_DIVIDER = 3'd0;
    localparam logic [SelW-1:0] SEL_COUNT   = 3'd1;
    localparam logic [SelW-1:0] SEL_RELOAD  = 3'd2;
    localparam logic [SelW-1:0] SEL_FLAGS   = 3'd3;
    localparam logic [SelW-1:0] SEL_MASK    = 3'd4;

    localparam logic [CfgIdxW-1:0] CFG_TIMER_ENABLE = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_TIMER_PERIOD = 1'b1;

    localparam logic [ByteW-1:0]   HALT_CYCLES     = 8'd4;
    localparam logic [TotalW-1:0]  DISPATCH_CYCLES = 9'd20;
    localparam logic [VecW-1:0]    VEC_BASE        = 7'h40;
    localparam logic [PeriodW-1:0] PERIOD_RESET    = 11'd1024;
    localparam logic [ByteW-1:0]   COUNT_MAX       = 8'hff;
    localparam int                 TimerFlagBit    = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FINISH
    } tic_state_t;

    typedef struct packed {
        logic accept;
        logic tick;
        logic finish;
    } tic_cmd_t;

    typedef struct packed {
        logic timed;
        logic presc_neg;
        logic out_free;
    } tic_status_t;

endpackage

### rtl/tic_req_if.sv
// Request channel carrying one bus or time-advance request
`timescale 1ns / 1ps
interface tic_req_if;
    logic                          valid;
    logic                          ready;
    logic [tic_pkg::FuncW-1:0]     func;
    logic [tic_pkg::ByteW-1:0]     cycles;
    logic                          cpu_halted;
    logic                          master_enable;
    logic [tic_pkg::SelW-1:0]      reg_sel;
    logic [tic_pkg::ByteW-1:0]     wdata;
    logic                          request_line;

    modport source (
        output valid, func, cycles, cpu_halted, master_enable, reg_sel, wdata, request_line,
        input  ready
    );
    modport sink (
        input  valid, func, cycles, cpu_halted, master_enable, reg_sel, wdata, request_line,
        output ready
    );
endinterface

### rtl/tic_rsp_if.sv
// Response channel carrying one result per request
`timescale 1ns / 1ps
interface tic_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tic_pkg::ByteW-1:0]     rdata;
    logic                          irq_taken;
    logic [tic_pkg::VecW-1:0]      vector;
    logic [tic_pkg::TotalW-1:0]    total_cycles;
    logic                          wake;

    modport source (
        output valid, rdata, irq_taken, vector, total_cycles, wake,
        input  ready
    );
    modport sink (
        input  valid, rdata, irq_taken, vector, total_cycles, wake,
        output ready
    );
endinterface

### rtl/tic_cfg_if.sv
// Configuration write channel
`timescale 1ns / 1ps
interface tic_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tic_pkg::CfgIdxW-1:0]   index;
    logic [tic_pkg::PeriodW-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/tic_dp.sv
// Datapath: timer state, register file, reload step, dispatch and result register
`timescale 1ns / 1ps
module tic_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tic_pkg::tic_cmd_t             cmd,
    output tic_pkg::tic_status_t          status,
    input  logic [tic_pkg::FuncW-1:0]     func,
    input  logic [tic_pkg::ByteW-1:0]     cycles,
    input  logic                          cpu_halted,
    input  logic                          master_enable,
    input  logic [tic_pkg::SelW-1:0]      reg_sel,
    input  logic [tic_pkg::ByteW-1:0]     wdata,
    input  logic                          request_line,
    input  logic                          cfg_we,
    input  logic [tic_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tic_pkg::PeriodW-1:0]   cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [tic_pkg::ByteW-1:0]     rdata,
    output logic                          irq_taken,
    output logic [tic_pkg::VecW-1:0]      vector,
    output logic [tic_pkg::TotalW-1:0]    total_cycles,
    output logic                          wake
);

    logic                                 enable_reg, enable_next;
    logic [tic_pkg::PeriodW-1:0]          period_reg, period_next;
    logic [tic_pkg::ByteW-1:0]            div_presc_reg, div_presc_next;
    logic [tic_pkg::ByteW-1:0]            divider_reg, divider_next;
    logic signed [tic_pkg::PrescW-1:0]    presc_reg, presc_next;
    logic [tic_pkg::ByteW-1:0]            count_reg, count_next;
    logic [tic_pkg::ByteW-1:0]            reload_reg, reload_next;
    logic [tic_pkg::ByteW-1:0]            flags_reg, flags_next;
    logic [tic_pkg::ByteW-1:0]            mask_reg, mask_next;

    logic [tic_pkg::FuncW-1:0]            item_func_reg, item_func_next;
    logic [tic_pkg::ByteW-1:0]            item_used_reg, item_used_next;
    logic                                 item_mie_reg, item_mie_next;
    logic [tic_pkg::ByteW-1:0]            item_rdata_reg, item_rdata_next;
    logic                                 item_wake_reg, item_wake_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [tic_pkg::ByteW-1:0]            out_rdata_reg, out_rdata_next;
    logic                                 out_irq_reg, out_irq_next;
    logic [tic_pkg::VecW-1:0]             out_vec_reg, out_vec_next;
    logic [tic_pkg::TotalW-1:0]           out_total_reg, out_total_next;
    logic                                 out_wake_reg, out_wake_next;

    logic [tic_pkg::ByteW-1:0]            used_in;
    logic [tic_pkg::ByteW:0]              div_sum;
    logic [tic_pkg::PrescW-1:0]           period_eff;
    logic [tic_pkg::ByteW-1:0]            read_mux;
    logic [tic_pkg::NumSrc-1:0]           pend;
    logic                                 found;
    logic [tic_pkg::SrcIdxW-1:0]          src;
    logic                                 dispatch;

    assign used_in    = cpu_halted ? tic_pkg::HALT_CYCLES : cycles;
    assign div_sum    = {1'b0, div_presc_reg} + {1'b0, used_in};
    assign period_eff = (period_reg == '0) ? tic_pkg::PrescW'(1)
                                           : tic_pkg::PrescW'(period_reg);
    assign pend       = flags_reg[tic_pkg::NumSrc-1:0] & mask_reg[tic_pkg::NumSrc-1:0];
    assign dispatch   = (item_func_reg == tic_pkg::FUNC_ADVANCE) && item_mie_reg && found;

    always_comb
    begin
        found = 1'b0;
        src   = '0;
        for (int k = 0; k < tic_pkg::NumSrc; k++)
        begin
            if (!found && pend[k])
            begin
                found = 1'b1;
                src   = tic_pkg::SrcIdxW'(k);
            end
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            tic_pkg::SEL_DIVIDER: read_mux = divider_reg;
            tic_pkg::SEL_COUNT:   read_mux = count_reg;
            tic_pkg::SEL_RELOAD:  read_mux = reload_reg;
            tic_pkg::SEL_FLAGS:   read_mux = flags_reg;
            tic_pkg::SEL_MASK:    read_mux = mask_reg;
            default:              read_mux = '0;
        endcase
    end

    assign status.timed     = (func == tic_pkg::FUNC_ADVANCE) && enable_reg;
    assign status.presc_neg = presc_reg[tic_pkg::PrescW-1];
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        enable_next     = enable_reg;
        period_next     = period_reg;
        div_presc_next  = div_presc_reg;
        divider_next    = divider_reg;
        presc_next      = presc_reg;
        count_next      = count_reg;
        reload_next     = reload_reg;
        flags_next      = flags_reg;
        mask_next       = mask_reg;
        item_func_next  = item_func_reg;
        item_used_next  = item_used_reg;
        item_mie_next   = item_mie_reg;
        item_rdata_next = item_rdata_reg;
        item_wake_next  = item_wake_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_rdata_next  = out_rdata_reg;
        out_irq_next    = out_irq_reg;
        out_vec_next    = out_vec_reg;
        out_total_next  = out_total_reg;
        out_wake_next   = out_wake_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                tic_pkg::CFG_TIMER_ENABLE: enable_next = cfg_data[0];
                tic_pkg::CFG_TIMER_PERIOD: period_next = cfg_data;
                default:                   period_next = period_reg;
            endcase
        end

        if (cmd.accept)
        begin
            item_func_next  = func;
            item_used_next  = used_in;
            item_mie_next   = master_enable;
            item_rdata_next = (func == tic_pkg::FUNC_READ) ? read_mux : '0;
            item_wake_next  = 1'b0;
            unique case (func)
                tic_pkg::FUNC_WRITE:
                begin
                    unique case (reg_sel)
                        tic_pkg::SEL_DIVIDER: divider_next = wdata;
                        tic_pkg::SEL_COUNT:   count_next   = wdata;
                        tic_pkg::SEL_RELOAD:  reload_next  = wdata;
                        tic_pkg::SEL_FLAGS:   flags_next   = wdata;
                        tic_pkg::SEL_MASK:    mask_next    = wdata;
                        default:              mask_next    = mask_reg;
                    endcase
                end
                tic_pkg::FUNC_RAISE:
                begin
                    flags_next = flags_reg | (request_line ? 8'h02 : 8'h01);
                end
                tic_pkg::FUNC_ADVANCE:
                begin
                    div_presc_next = div_sum[tic_pkg::ByteW-1:0];
                    if (div_sum[tic_pkg::ByteW])
                    begin
                        divider_next = divider_reg + 8'd1;
                    end
                    if (enable_reg)
                    begin
                        presc_next = presc_reg - $signed(tic_pkg::PrescW'(used_in));
                    end
                end
                default:
                begin
                    item_wake_next = 1'b0;
                end
            endcase
        end

        if (cmd.tick)
        begin
            presc_next = presc_reg + $signed(period_eff);
            if (count_reg == tic_pkg::COUNT_MAX)
            begin
                count_next                        = reload_reg;
                flags_next[tic_pkg::TimerFlagBit] = 1'b1;
                item_wake_next                    = 1'b1;
            end
            else
            begin
                count_next = count_reg + 8'd1;
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_rdata_next = item_rdata_reg;
            out_irq_next   = dispatch;
            out_vec_next   = dispatch ? tic_pkg::VEC_BASE + tic_pkg::VecW'({src, 3'b000}) : '0;
            out_wake_next  = item_wake_reg || dispatch;
            if (item_func_reg == tic_pkg::FUNC_ADVANCE)
            begin
                out_total_next = tic_pkg::TotalW'(item_used_reg)
                               + (dispatch ? tic_pkg::DISPATCH_CYCLES : '0);
            end
            else
            begin
                out_total_next = '0;
            end
            if (dispatch)
            begin
                flags_next[src] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            period_reg    <= tic_pkg::PERIOD_RESET;
            div_presc_reg <= '0;
            divider_reg   <= '0;
            presc_reg     <= '0;
            count_reg     <= '0;
            reload_reg    <= '0;
            flags_reg     <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg    <= enable_next;
            period_reg    <= period_next;
            div_presc_reg <= div_presc_next;
            divider_reg   <= divider_next;
            presc_reg     <= presc_next;
            count_reg     <= count_next;
            reload_reg    <= reload_next;
            flags_reg     <= flags_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_func_reg  <= item_func_next;
        item_used_reg  <= item_used_next;
        item_mie_reg   <= item_mie_next;
        item_rdata_reg <= item_rdata_next;
        item_wake_reg  <= item_wake_next;
        out_rdata_reg  <= out_rdata_next;
        out_irq_reg    <= out_irq_next;
        out_vec_reg    <= out_vec_next;
        out_total_reg  <= out_total_next;
        out_wake_reg   <= out_wake_next;
    end

    assign out_valid    = out_valid_reg;
    assign rdata        = out_rdata_reg;
    assign irq_taken    = out_irq_reg;
    assign vector       = out_vec_reg;
    assign total_cycles = out_total_reg;
    assign wake         = out_wake_reg;

endmodule

### rtl/tic_ctrl.sv
// Controller state machine sequencing accept, reload steps and result write
`timescale 1ns / 1ps
module tic_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tic_pkg::tic_status_t  status,
    output tic_pkg::tic_cmd_t     cmd
);

    tic_pkg::tic_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tic_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.timed ? tic_pkg::ST_TICK : tic_pkg::ST_FINISH;
                end
            end
            tic_pkg::ST_TICK:
            begin
                if (!status.presc_neg)
                begin
                    state_next = tic_pkg::ST_FINISH;
                end
            end
            tic_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = tic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tic_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            tic_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            tic_pkg::ST_TICK:
            begin
                cmd.tick = status.presc_neg;
            end
            tic_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tic_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/timer_and_interrupt_controller_unit.sv
// Top level of the timer and interrupt controller
//
// Requests arrive on req (valid/ready): time advance, register write, register read or
// request raise. Each request gives exactly one result on rsp (valid/ready), in order.
// Configuration (timer enable, timer period) is written on cfg, always ready; write it
// only while no request is in flight.
// A non-timed request goes from accept straight to the result write into the output
// register, which waits for that register to be free. A time advance with the timer
// enabled runs n prescaler reloads between accept and result write: one shared add per
// cycle in the reload step, so n runs from 0 up to 255 for a period of 1. A new request
// is accepted once the previous result is in the output register, not while one is worked.
// When rsp stalls, the result holds in the output register; the next request is still
// accepted and worked, and waits in its final step until the output register frees.
// Reset clears all timer state, flags and mask, disables the timer and sets the period
// to 1024; no result is pending after reset.
`timescale 1ns / 1ps
`include "timer_and_interrupt_controller_unit_macros.svh"
module timer_and_interrupt_controller_unit (
    input  logic    clk,
    input  logic    rst_n,
    tic_req_if.sink req,
    tic_rsp_if.source rsp,
    tic_cfg_if.sink cfg
);

    tic_pkg::tic_cmd_t    cmd;
    tic_pkg::tic_status_t status;
    logic                 in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    tic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tic_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (req.func),
        .cycles        (req.cycles),
        .cpu_halted    (req.cpu_halted),
        .master_enable (req.master_enable),
        .reg_sel       (req.reg_sel),
        .wdata         (req.wdata),
        .request_line  (req.request_line),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .rdata         (rsp.rdata),
        .irq_taken     (rsp.irq_taken),
        .vector        (rsp.vector),
        .total_cycles  (rsp.total_cycles),
        .wake          (rsp.wake)
    );

    `TIC_ASSERT_NXT(a_busy_after_accept, req.valid && in_ready, !in_ready)
    `TIC_ASSERT_IMP(a_irq_wakes, rsp.valid && rsp.irq_taken, rsp.wake && rsp.vector != '0)
    `TIC_ASSERT_IMP(a_no_irq_no_vec, rsp.valid && !rsp.irq_taken, rsp.vector == '0)
    `TIC_ASSERT_IMP(a_read_quiet, rsp.valid && rsp.rdata != '0,
        rsp.total_cycles == '0 && !rsp.wake)

endmodule

### dv/tb_timer_and_interrupt_controller_unit.sv
// Self-checking testbench of the timer and interrupt controller: directed table, random phases
`timescale 1ns / 1ps
module tb_timer_and_interrupt_controller_unit;
    import tic_pkg::*;

    localparam int Half         = 5;
    localparam int ResetCycles  = 11;
    localparam int NumRows      = 30;
    localparam int NumPhases    = 8;
    localparam int PhaseItems   = 203;
    localparam int LongHold     = 300;
    localparam int SettleCycles = 300;
    localparam int Patience     = 4000;
    localparam int VecStep      = 8;
    localparam int PrintCap     = 40;

    localparam logic [SelW-1:0] SEL_SPARE_LO = 3'd5;
    localparam logic [SelW-1:0] SEL_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [FuncW-1:0] func;
        logic [ByteW-1:0] cycles;
        logic             cpu_halted;
        logic             master_enable;
        logic [SelW-1:0]  reg_sel;
        logic [ByteW-1:0] wdata;
        logic             request_line;
    } request_t;

    typedef struct packed {
        logic [ByteW-1:0]  rdata;
        logic              irq_taken;
        logic [VecW-1:0]   vector;
        logic [TotalW-1:0] total_cycles;
        logic              wake;
    } result_t;

    typedef struct packed {
        logic                is_cfg;
        logic [CfgIdxW-1:0]  cfg_index;
        logic [PeriodW-1:0]  cfg_data;
        request_t            rq;
        logic                pinned;
        result_t             want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    tic_req_if req ();
    tic_rsp_if rsp ();
    tic_cfg_if cfg ();

    timer_and_interrupt_controller_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #(Half) clk = ~clk;

    logic                      tmr_on       = 1'b0;
    logic [PeriodW-1:0]        tmr_period   = PERIOD_RESET;
    logic [ByteW-1:0]          div_phase    = '0;
    logic [ByteW-1:0]          div_count    = '0;
    logic signed [PrescW-1:0]  tmr_phase    = '0;
    logic [ByteW-1:0]          tmr_count    = '0;
    logic [ByteW-1:0]          tmr_reload   = '0;
    logic [ByteW-1:0]          irq_flags    = '0;
    logic [ByteW-1:0]          irq_mask     = '0;

    result_t awaited [$];
    row_t    plan [NumRows];
    logic    steady = 1'b0;
    int      n_errors = 0;
    int      results_seen = 0;
    int      n_requests = 0;
    int      n_dispatch = 0;
    int      n_overflow = 0;
    int      n_settings = 0;

    function automatic result_t timer_irq_step(request_t r);
        result_t          o;
        int               used;
        int               span;
        int               d;
        logic [ByteW-1:0] pend;
        logic             done;
        o = '0;
        case (r.func)
            FUNC_WRITE:
                case (r.reg_sel)
                    SEL_DIVIDER: div_count  = r.wdata;
                    SEL_COUNT:   tmr_count  = r.wdata;
                    SEL_RELOAD:  tmr_reload = r.wdata;
                    SEL_FLAGS:   irq_flags  = r.wdata;
                    SEL_MASK:    irq_mask   = r.wdata;
                    default:     ;
                endcase
            FUNC_READ:
                case (r.reg_sel)
                    SEL_DIVIDER: o.rdata = div_count;
                    SEL_COUNT:   o.rdata = tmr_count;
                    SEL_RELOAD:  o.rdata = tmr_reload;
                    SEL_FLAGS:   o.rdata = irq_flags;
                    SEL_MASK:    o.rdata = irq_mask;
                    default:     o.rdata = '0;
                endcase
            FUNC_RAISE:
                irq_flags[r.request_line] = 1'b1;
            default:
            begin
                used = r.cpu_halted ? int'(HALT_CYCLES) : int'(r.cycles);
                d = int'(div_phase) + used;
                if (d > 255)
                begin
                    d -= 256;
                    div_count = div_count + 1'b1;
                end
                div_phase = ByteW'(d);
                if (tmr_on)
                begin
                    span = (tmr_period == '0) ? 1 : int'(tmr_period);
                    tmr_phase = tmr_phase - PrescW'(used);
                    while (tmr_phase < 0)
                    begin
                        tmr_phase = tmr_phase + PrescW'(span);
                        if (tmr_count == COUNT_MAX)
                        begin
                            tmr_count = tmr_reload;
                            irq_flags[TimerFlagBit] = 1'b1;
                            o.wake = 1'b1;
                            n_overflow++;
                        end
                        else
                        begin
                            tmr_count = tmr_count + 1'b1;
                        end
                    end
                end
                o.total_cycles = TotalW'(used);
                if (r.master_enable)
                begin
                    pend = irq_flags & irq_mask;
                    done = 1'b0;
                    for (int k = 0; k < NumSrc; k++)
                    begin
                        if (!done && pend[k])
                        begin
                            irq_flags[k] = 1'b0;
                            o.irq_taken = 1'b1;
                            o.vector = VecW'(int'(VEC_BASE) + VecStep * k);
                            o.total_cycles = o.total_cycles + DISPATCH_CYCLES;
                            o.wake = 1'b1;
                            done = 1'b1;
                            n_dispatch++;
                        end
                    end
                end
            end
        endcase
        return o;
    endfunction

    function automatic row_t req_row(logic [FuncW-1:0] func, logic [ByteW-1:0] cycles,
                                     logic halted, logic mie, logic [SelW-1:0] sel,
                                     logic [ByteW-1:0] wdata, logic line);
        row_t w;
        w = '0;
        w.rq.func          = func;
        w.rq.cycles        = cycles;
        w.rq.cpu_halted    = halted;
        w.rq.master_enable = mie;
        w.rq.reg_sel       = sel;
        w.rq.wdata         = wdata;
        w.rq.request_line  = line;
        return w;
    endfunction

    function automatic row_t pin(row_t w, logic [ByteW-1:0] rdata, logic taken,
                                 logic [VecW-1:0] vec, logic [TotalW-1:0] total, logic wake);
        w.pinned            = 1'b1;
        w.want.rdata        = rdata;
        w.want.irq_taken    = taken;
        w.want.vector       = vec;
        w.want.total_cycles = total;
        w.want.wake         = wake;
        return w;
    endfunction

    function automatic row_t cfg_row(logic [CfgIdxW-1:0] index, logic [PeriodW-1:0] data);
        row_t w;
        w = '0;
        w.is_cfg    = 1'b1;
        w.cfg_index = index;
        w.cfg_data  = data;
        return w;
    endfunction

    function automatic request_t draw_request();
        request_t r;
        int       pick;
        pick = $urandom_range(99);
        r.func = (pick < 50) ? FUNC_ADVANCE :
                 (pick < 70) ? FUNC_WRITE :
                 (pick < 88) ? FUNC_READ : FUNC_RAISE;
        r.cycles = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
                                            : ByteW'($urandom_range(255));
        r.cpu_halted    = ($urandom_range(7) == 0);
        r.master_enable = 1'($urandom_range(1));
        r.reg_sel = ($urandom_range(9) == 0) ? SelW'($urandom_range(7))
                                             : SelW'($urandom_range(4));
        r.wdata = ByteW'($urandom_range(255));
        if (r.func == FUNC_WRITE && r.reg_sel == SEL_COUNT && $urandom_range(1))
            r.wdata = ByteW'($urandom_range(255, 240));
        r.request_line = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic report_mismatch(input string line);
        if (n_errors < PrintCap)
            $display("MISMATCH %s", line);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    task automatic offer(input request_t r, input logic pinned, input result_t want);
        result_t model_out;
        int      gap;
        int      pick;
        req.valid         <= 1'b1;
        req.func          <= r.func;
        req.cycles        <= r.cycles;
        req.cpu_halted    <= r.cpu_halted;
        req.master_enable <= r.master_enable;
        req.reg_sel       <= r.reg_sel;
        req.wdata         <= r.wdata;
        req.request_line  <= r.request_line;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        model_out = timer_irq_step(r);
        awaited.push_back(pinned ? want : model_out);
        n_requests++;
        pick = $urandom_range(99);
        gap = steady      ? 0 :
              (pick < 60) ? 0 :
              (pick < 90) ? $urandom_range(3, 1) :
              (pick < 98) ? $urandom_range(12, 4) : $urandom_range(60, 20);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_setting(input logic [CfgIdxW-1:0] index,
                                 input logic [PeriodW-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (index == CFG_TIMER_ENABLE)
            tmr_on = data[0];
        else
            tmr_period = data;
        n_settings++;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing awaited",
                                          results_seen));
            end
            else
            begin
                result_t want;
                want = awaited.pop_front();
                check_field("rdata", 16'(rsp.rdata), 16'(want.rdata));
                check_field("irq_taken", 16'(rsp.irq_taken), 16'(want.irq_taken));
                check_field("vector", 16'(rsp.vector), 16'(want.vector));
                check_field("total_cycles", 16'(rsp.total_cycles), 16'(want.total_cycles));
                check_field("wake", 16'(rsp.wake), 16'(want.wake));
            end
        end
    end

    initial
    begin
        int   stall;
        int   beat;
        int   pick;
        logic held;
        stall = 0;
        beat  = 0;
        held  = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            beat++;
            if (stall > 0)
            begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else if (!held && results_seen >= 400)
            begin
                held  = 1'b1;
                stall = LongHold;
                rsp.ready <= 1'b0;
            end
            else if (beat % 600 < 150)
            begin
                rsp.ready <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    rsp.ready <= 1'b1;
                else
                begin
                    stall = (pick < 97) ? $urandom_range(3, 0) : $urandom_range(40, 10);
                    rsp.ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < Patience)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_timer_and_interrupt_controller_unit failed");
        $finish;
    end

    initial
    begin
        logic               phase_on     [NumPhases];
        logic [PeriodW-1:0] phase_period [NumPhases];
        rst_n = 1'b0;
        req.valid         <= 1'b0;
        req.func          <= FUNC_ADVANCE;
        req.cycles        <= '0;
        req.cpu_halted    <= 1'b0;
        req.master_enable <= 1'b0;
        req.reg_sel       <= SEL_DIVIDER;
        req.wdata         <= '0;
        req.request_line  <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= CFG_TIMER_ENABLE;
        cfg.data          <= '0;
        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan = '{
            pin(req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_DIVIDER, 8'h00, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_COUNT, 8'h00, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_FLAGS, 8'h00, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_MASK, 8'h00, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_WRITE, 8'hff, 1'b1, 1'b1, SEL_SPARE_HI, 8'hff, 1'b1),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_READ, 8'hff, 1'b1, 1'b1, SEL_SPARE_LO, 8'hff, 1'b1),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_WRITE, 8'h00, 1'b0, 1'b0, SEL_MASK, 8'hff, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_MASK, 8'h00, 1'b0),
                8'hff, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_RAISE, 8'h00, 1'b0, 1'b0, SEL_DIVIDER, 8'h00, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_RAISE, 8'h00, 1'b0, 1'b0, SEL_DIVIDER, 8'h00, 1'b1),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_FLAGS, 8'h00, 1'b0),
                8'h03, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_ADVANCE, 8'hff, 1'b0, 1'b0, SEL_DIVIDER, 8'h00, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd255, 1'b0),
            pin(req_row(FUNC_ADVANCE, 8'd200, 1'b1, 1'b1, SEL_DIVIDER, 8'h00, 1'b0),
                8'h00, 1'b1, 7'h40, 9'd24, 1'b1),
            pin(req_row(FUNC_ADVANCE, 8'h00, 1'b0, 1'b1, SEL_DIVIDER, 8'h00, 1'b0),
                8'h00, 1'b1, 7'h48, 9'd20, 1'b1),
            pin(req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_DIVIDER, 8'h00, 1'b0),
                8'h01, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_WRITE, 8'h00, 1'b0, 1'b0, SEL_FLAGS, 8'hf8, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_ADVANCE, 8'h00, 1'b0, 1'b1, SEL_DIVIDER, 8'h00, 1'b0),
                8'h00, 1'b1, 7'h58, 9'd20, 1'b1),
            pin(req_row(FUNC_ADVANCE, 8'h00, 1'b0, 1'b1, SEL_DIVIDER, 8'h00, 1'b0),
                8'h00, 1'b1, 7'h60, 9'd20, 1'b1),
            pin(req_row(FUNC_ADVANCE, 8'h00, 1'b0, 1'b1, SEL_DIVIDER, 8'h00, 1'b0),
                8'h00, 1'b0, 7'h00, 9'd0, 1'b0),
            pin(req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_FLAGS, 8'h00, 1'b0),
                8'he0, 1'b0, 7'h00, 9'd0, 1'b0),
            cfg_row(CFG_TIMER_ENABLE, 11'd1),
            cfg_row(CFG_TIMER_PERIOD, 11'd0),
            req_row(FUNC_WRITE, 8'h00, 1'b0, 1'b0, SEL_RELOAD, 8'hff, 1'b0),
            req_row(FUNC_WRITE, 8'h00, 1'b0, 1'b0, SEL_COUNT, 8'hfe, 1'b0),
            req_row(FUNC_ADVANCE, 8'd3, 1'b0, 1'b0, SEL_DIVIDER, 8'h00, 1'b0),
            req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_COUNT, 8'h00, 1'b0),
            req_row(FUNC_ADVANCE, 8'h00, 1'b0, 1'b1, SEL_DIVIDER, 8'h00, 1'b0),
            cfg_row(CFG_TIMER_PERIOD, 11'd2047),
            req_row(FUNC_ADVANCE, 8'hff, 1'b0, 1'b1, SEL_DIVIDER, 8'h00, 1'b0),
            req_row(FUNC_READ, 8'h00, 1'b0, 1'b0, SEL_FLAGS, 8'h00, 1'b0)
        };

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_setting(plan[i].cfg_index, plan[i].cfg_data);
            end
            else
            begin
                offer(plan[i].rq, plan[i].pinned, plan[i].want);
            end
        end

        phase_on     = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        phase_period = '{PERIOD_RESET, 11'd1, 11'd16, 11'd0, 11'd0, 11'd2047,
                         PeriodW'($urandom_range(1024, 1)), PeriodW'($urandom_range(64, 2))};

        for (int p = 0; p < NumPhases; p++)
        begin
            drain();
            write_setting(CFG_TIMER_ENABLE,
                          {(PeriodW-1)'($urandom_range(1023)), phase_on[p]});
            write_setting(CFG_TIMER_PERIOD, phase_period[p]);
            for (int i = 0; i < PhaseItems; i++)
            begin
                if (p == 2 && i == PhaseItems / 2)
                    drain();
                steady = (i % 64) < 16;
                offer(draw_request(), 1'b0, '0);
            end
            steady = 1'b0;
        end

        drain();
        repeat (SettleCycles) @(posedge clk);
        $display("checked %0d results from %0d requests across %0d timer settings",
                 results_seen, n_requests, n_settings);
        $display("predicted %0d interrupt dispatches and %0d timer overflows",
                 n_dispatch, n_overflow);
        if (n_errors == 0)
            $display("tb_timer_and_interrupt_controller_unit passed");
        else
            $display("tb_timer_and_interrupt_controller_unit failed");
        $finish;
    end

endmodule
